FILE: sv/stbs_pkg.sv
// shared types and constants of the sorted table binary search core
`default_nettype none

package stbs_pkg;

   localparam int TABLE_DEPTH   = 1024;
   localparam int IDX_W         = $clog2(TABLE_DEPTH);
   localparam int PROBES        = IDX_W + 1;
   localparam int DATA_W        = 64;
   localparam int INDEX_FIELD_W = 10;
   localparam int END_FIELD_W   = 11;
   localparam int RANGE_W       = ((IDX_W > INDEX_FIELD_W) ? IDX_W : INDEX_FIELD_W) + 2;

   localparam logic signed [RANGE_W-1:0] LAST_POS  = RANGE_W'(TABLE_DEPTH - 1);
   localparam logic signed [RANGE_W-1:0] RANGE_ONE = RANGE_W'(1);

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef struct packed {
      logic                      valid;
      logic                      cmd;
      logic                      wr_ok;
      logic [IDX_W-1:0]          widx;
      logic [DATA_W-1:0]         data;
      logic signed [RANGE_W-1:0] lo;
      logic signed [RANGE_W-1:0] hi;
      logic                      done;
      logic                      found;
      logic [IDX_W-1:0]          pos;
      logic [IDX_W-1:0]          mid;
   } stage_type;

endpackage

`default_nettype wire

FILE: sv/stbs_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module stbs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/sorted_table_binary_search_core.sv
// pipelined binary search over a sorted table of signed 64-bit entries
//
//   channel  dir  transfer when          carries
//   req_     in   req_valid & req_ready  cmd, write_index, write_value,
//                                        range_start, range_end, search_key
//   rsp_     out  rsp_valid & rsp_ready  found, position (search items only)
//
// one item enters per cycle while the pipeline is not frozen; a search result
// leaves through the input register, one probe stage per halving step and a
// final result register, each probe stage reading its own copy of the table; a
// write item updates each copy as it passes that stage and gives no result
// reset clears the stage valid bits only; table contents stay undefined until written
// a result held with rsp_ready low freezes the whole pipeline and req_ready drops
`default_nettype none

module sorted_table_binary_search_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_cmd,
   input  logic [stbs_pkg::INDEX_FIELD_W-1:0]       req_write_index,
   input  logic signed [stbs_pkg::DATA_W-1:0]       req_write_value,
   input  logic [stbs_pkg::INDEX_FIELD_W-1:0]       req_range_start,
   input  logic signed [stbs_pkg::END_FIELD_W-1:0]  req_range_end,
   input  logic signed [stbs_pkg::DATA_W-1:0]       req_search_key,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_found,
   output logic [stbs_pkg::INDEX_FIELD_W-1:0]       rsp_position
);

   import stbs_pkg::*;

   localparam int NS = PROBES + 2;

   stage_type stage_ff [NS];
   stage_type stage_in [NS];
   stage_type resolved [PROBES+1];
   logic [DATA_W-1:0] rd_data [PROBES];
   logic advance;

   // input capture
   stage_type in_item;
   logic signed [RANGE_W-1:0] start_ext;
   logic signed [RANGE_W-1:0] end_ext;

   always_comb begin
      start_ext = $signed(RANGE_W'(req_range_start));
      end_ext   = RANGE_W'(req_range_end);
      if (end_ext > LAST_POS) begin
         end_ext = LAST_POS;
      end
      in_item       = '0;
      in_item.valid = req_valid;
      in_item.cmd   = req_cmd;
      in_item.wr_ok = (32'(req_write_index) < 32'(TABLE_DEPTH));
      in_item.widx  = IDX_W'(req_write_index);
      in_item.data  = (req_cmd == CMD_WRITE) ? req_write_value : req_search_key;
      in_item.lo    = start_ext;
      in_item.hi    = end_ext;
   end

   assign stage_in[0] = in_item;
   assign resolved[0] = stage_ff[0];

   // apply the probe result read from the previous stage's table copy
   for (genvar k = 1; k <= PROBES; k++) begin : gen_resolve
      stage_type cur;
      stage_type res;
      logic signed [RANGE_W-1:0] mid_ext;
      logic [DATA_W-1:0] entry;

      assign cur   = stage_ff[k];
      assign entry = rd_data[k-1];

      always_comb begin
         res     = cur;
         mid_ext = $signed(RANGE_W'(cur.mid));
         if (cur.valid && (cur.cmd == CMD_SEARCH) && !cur.done && (cur.lo <= cur.hi)) begin
            if (entry == cur.data) begin
               res.done  = 1'b1;
               res.found = 1'b1;
               res.pos   = cur.mid;
            end else if ($signed(entry) < $signed(cur.data)) begin
               res.lo = mid_ext + RANGE_ONE;
            end else begin
               res.hi = mid_ext - RANGE_ONE;
            end
         end
      end

      assign resolved[k] = res;
   end

   // issue the next probe and carry writes down every table copy
   for (genvar k = 0; k < PROBES; k++) begin : gen_probe
      stage_type nxt;
      logic signed [RANGE_W-1:0] sum;
      logic [IDX_W-1:0] mid;
      logic wr_en;

      always_comb begin
         sum     = resolved[k].lo + resolved[k].hi;
         mid     = sum[IDX_W:1];
         nxt     = resolved[k];
         nxt.mid = mid;
      end

      assign wr_en = advance && stage_ff[k].valid && (stage_ff[k].cmd == CMD_WRITE)
                     && stage_ff[k].wr_ok;

      stbs_ram #(
         .WIDTH (DATA_W),
         .DEPTH (TABLE_DEPTH)
      ) u_table (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (stage_ff[k].widx),
         .wr_data (stage_ff[k].data),
         .rd_en   (advance),
         .rd_addr (mid),
         .rd_data (rd_data[k])
      );

      assign stage_in[k+1] = nxt;
   end

   assign stage_in[NS-1] = resolved[PROBES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            stage_ff[i].valid <= 1'b0;
         end
      end else if (advance) begin
         for (int i = 0; i < NS; i++) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign rsp_valid    = stage_ff[NS-1].valid && (stage_ff[NS-1].cmd == CMD_SEARCH);
   assign rsp_found    = stage_ff[NS-1].found;
   assign rsp_position = INDEX_FIELD_W'(stage_ff[NS-1].pos);
   assign advance      = !rsp_valid || rsp_ready;
   assign req_ready    = advance;

endmodule

`default_nettype wire

FILE: sv/stbs_checker.sv
// port level checks for the sorted table binary search core, with its bind
`default_nettype none

module stbs_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_ready,
   input  logic                                     req_cmd,
   input  logic [stbs_pkg::INDEX_FIELD_W-1:0]       req_write_index,
   input  logic signed [stbs_pkg::DATA_W-1:0]       req_write_value,
   input  logic [stbs_pkg::INDEX_FIELD_W-1:0]       req_range_start,
   input  logic signed [stbs_pkg::END_FIELD_W-1:0]  req_range_end,
   input  logic signed [stbs_pkg::DATA_W-1:0]       req_search_key,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   input  logic                                     rsp_found,
   input  logic [stbs_pkg::INDEX_FIELD_W-1:0]       rsp_position
);

   import stbs_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_position))
      else $error("rsp transfer changed while stalled");

   // not found reports position zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("miss with nonzero position");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

   // input side moves exactly when the output side can
   a_global_stall: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready out of step with rsp side");

endmodule

bind sorted_table_binary_search_core stbs_checker u_checker (.*);

`default_nettype wire
